// File: src/ctt_pkg.sv
// Shared types, codes and helpers of the config text tokenizer.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package ctt_pkg;

	localparam int PosBits  = 16;
	localparam int FieldPos = 16;
	localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

	typedef enum logic [2:0] {
		KIND_EOF    = 3'd0,
		KIND_STRING = 3'd1,
		KIND_IDENT  = 3'd2,
		KIND_LBRACE = 3'd3,
		KIND_RBRACE = 3'd4,
		KIND_EQUAL  = 3'd5,
		KIND_COLON  = 3'd6,
		KIND_SEMI   = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_UNTERM     = 2'd1,
		ERR_BAD_ESCAPE = 2'd2,
		ERR_BAD_BYTE   = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		kind_t                token_kind;
		logic                 token_start;
		logic                 token_end;
		logic                 has_char;
		logic [7:0]           char_value;
		logic [FieldPos-1:0]  start_line;
		logic [FieldPos-1:0]  start_column;
		err_t                 error_code;
		logic                 last_of_item;
	} out_item_t;

	// Byte class worked out by the front part.
	typedef struct packed {
		logic       bad;
		logic       space;
		logic       newline;
		logic       hash;
		logic       squote;
		logic       dquote;
		logic       bslash;
		logic       is_mark;
		kind_t      mark_kind;
		logic       esc_known;
		logic       esc_dollar;
		logic [7:0] esc_value;
	} byte_class_t;

	// One queue word: byte, end flag, class and event position.
	typedef struct packed {
		logic [7:0]         text_byte;
		logic               end_of_input;
		byte_class_t        cls;
		logic [PosBits-1:0] line;
		logic [PosBits-1:0] column;
	} entry_t;

	function automatic logic [PosBits-1:0] pos_inc(input logic [PosBits-1:0] v);
		pos_inc = (v == PosMax) ? PosMax : v + PosBits'(1);
	endfunction

	function automatic logic [FieldPos-1:0] pos_field(input logic [PosBits-1:0] v);
		pos_field = FieldPos'(v);
	endfunction

endpackage

// File: src/config_text_tokenizer_unit.sv
// Top level of the config text tokenizer: front, queue and back parts.
// Depends on ctt_pkg, ctt_front, ctt_fifo and ctt_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------
//   input    | in_valid, in_ready  | in_item  (text_byte, end_of_input)
//   result   | out_valid, out_ready| out_item (token event, 9 fields)
//
// One input word per cycle while the queue is not full; an item with two results
// holds the back part until its second result leaves the one second-result slot
// for the single output register. Words pass the queue, then the output register.
// The four-word queue lets the input side run on while the result side stalls;
// in_ready drops only when the queue is full.
// Reset clears position (line 1, column 0), lexer mode and all valid flags.
`timescale 1ns / 1ps

module config_text_tokenizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ctt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ctt_pkg::out_item_t out_item
);

	ctt_pkg::entry_t entry;
	ctt_pkg::entry_t head_word;
	logic            accept;
	logic            full;
	logic            head_valid;
	logic            pop;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	ctt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item),
		.entry  (entry)
	);

	ctt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_word  (entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_word  (head_word)
	);

	ctt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

// File: src/ctt_front.sv
// Front part: tracks line and column and classifies each byte.
// Depends on ctt_pkg; feeds ctt_fifo with one entry_t word per item.
`timescale 1ns / 1ps

module ctt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  ctt_pkg::in_item_t item,
	output ctt_pkg::entry_t   entry
);

	logic [ctt_pkg::PosBits-1:0] line_q;
	logic [ctt_pkg::PosBits-1:0] col_q;
	logic [ctt_pkg::PosBits-1:0] line_d;
	logic [ctt_pkg::PosBits-1:0] col_d;
	logic [7:0]                  c;
	ctt_pkg::byte_class_t        cls;

	assign c = item.text_byte;

	always_comb begin
		if (item.end_of_input) begin
			line_d = line_q;
			col_d  = ctt_pkg::pos_inc(col_q);
		end else if (c == 8'h0A) begin
			line_d = ctt_pkg::pos_inc(line_q);
			col_d  = '0;
		end else begin
			line_d = line_q;
			col_d  = ctt_pkg::pos_inc(col_q);
		end
	end

	always_comb begin
		cls            = '0;
		cls.bad        = (c == 8'h00) || c[7];
		cls.newline    = (c == 8'h0A);
		cls.space      = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
		                 (c == 8'h0B) || (c == 8'h0D);
		cls.hash       = (c == 8'h23);
		cls.squote     = (c == 8'h27);
		cls.dquote     = (c == 8'h22);
		cls.bslash     = (c == 8'h5C);
		cls.mark_kind  = ctt_pkg::KIND_EOF;
		case (c)
			8'h7B:   cls.mark_kind = ctt_pkg::KIND_LBRACE;
			8'h7D:   cls.mark_kind = ctt_pkg::KIND_RBRACE;
			8'h3D:   cls.mark_kind = ctt_pkg::KIND_EQUAL;
			8'h3A:   cls.mark_kind = ctt_pkg::KIND_COLON;
			8'h3B:   cls.mark_kind = ctt_pkg::KIND_SEMI;
			default: cls.mark_kind = ctt_pkg::KIND_EOF;
		endcase
		cls.is_mark    = (cls.mark_kind != ctt_pkg::KIND_EOF);
		cls.esc_known  = 1'b1;
		cls.esc_value  = c;
		case (c)
			8'h5C, 8'h27, 8'h22: cls.esc_value = c;
			8'h30:   cls.esc_value = 8'h00;
			8'h74:   cls.esc_value = 8'h09;
			8'h76:   cls.esc_value = 8'h0B;
			8'h72:   cls.esc_value = 8'h0D;
			8'h6E:   cls.esc_value = 8'h0A;
			default: cls.esc_known = 1'b0;
		endcase
		cls.esc_dollar = (c == 8'h24);
	end

	assign entry.text_byte    = c;
	assign entry.end_of_input = item.end_of_input;
	assign entry.cls          = cls;
	assign entry.line         = line_d;
	assign entry.column       = col_d;

	// End mark reports the bumped column, then restarts at line 1, column 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= ctt_pkg::PosBits'(1);
			col_q  <= '0;
		end else if (accept) begin
			if (item.end_of_input) begin
				line_q <= ctt_pkg::PosBits'(1);
				col_q  <= '0;
			end else begin
				line_q <= line_d;
				col_q  <= col_d;
			end
		end
	end

endmodule

// File: src/ctt_fifo.sv
// Four-word queue between the front and back parts.
// Depends on ctt_pkg for the entry_t word type.
`timescale 1ns / 1ps

module ctt_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ctt_pkg::entry_t push_word,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ctt_pkg::entry_t head_word
);

	ctt_pkg::entry_t mem_q [4];
	logic [1:0]      wr_ptr_q;
	logic [1:0]      rd_ptr_q;
	logic [2:0]      count_q;

	assign full       = (count_q == 3'd4);
	assign head_valid = (count_q != 3'd0);
	assign head_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 3'd1;
				2'b01:   count_q <= count_q - 3'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/ctt_back.sv
// Back part: lexer state machine, result generation and output staging.
// Depends on ctt_pkg; takes words from ctt_fifo and drives the result channel.
`timescale 1ns / 1ps

module ctt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  ctt_pkg::entry_t    head_word,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output ctt_pkg::out_item_t out_item
);

	typedef enum logic [7:0] {
		M_BETWEEN = 8'b0000_0001,
		M_COMMENT = 8'b0000_0010,
		M_STR_S   = 8'b0000_0100,
		M_ESC_S   = 8'b0000_1000,
		M_STR_D   = 8'b0001_0000,
		M_ESC_D   = 8'b0010_0000,
		M_IDENT   = 8'b0100_0000,
		M_ERROR   = 8'b1000_0000
	} mode_t;

	mode_t                       mode_q;
	mode_t                       mode_d;
	logic [ctt_pkg::PosBits-1:0] tok_line_q;
	logic [ctt_pkg::PosBits-1:0] tok_col_q;
	logic [ctt_pkg::PosBits-1:0] tok_line_d;
	logic [ctt_pkg::PosBits-1:0] tok_col_d;
	logic                        out_valid_q;
	ctt_pkg::out_item_t          out_q;
	logic                        pend_q;
	ctt_pkg::out_item_t          pend_item_q;

	ctt_pkg::byte_class_t cls;
	logic [7:0]           c;
	logic [15:0]          ev_line;
	logic [15:0]          ev_col;
	logic [15:0]          tk_line;
	logic [15:0]          tk_col;

	// start-of-token decode
	ctt_pkg::out_item_t st_res;
	logic               st_emit;
	logic               st_tok;
	mode_t              st_mode;

	ctt_pkg::out_item_t r0;
	ctt_pkg::out_item_t r1;
	logic [1:0]         n;

	assign cls     = head_word.cls;
	assign c       = head_word.text_byte;
	assign ev_line = ctt_pkg::pos_field(head_word.line);
	assign ev_col  = ctt_pkg::pos_field(head_word.column);
	assign tk_line = ctt_pkg::pos_field(tok_line_q);
	assign tk_col  = ctt_pkg::pos_field(tok_col_q);

	always_comb begin
		st_res              = '0;
		st_res.start_line   = ev_line;
		st_res.start_column = ev_col;
		st_res.token_start  = 1'b1;
		st_emit             = 1'b0;
		st_tok              = 1'b0;
		st_mode             = M_BETWEEN;
		if (cls.space) begin
			st_mode = M_BETWEEN;
		end else if (cls.hash) begin
			st_mode = M_COMMENT;
		end else if (cls.squote || cls.dquote) begin
			st_emit           = 1'b1;
			st_tok            = 1'b1;
			st_mode           = cls.squote ? M_STR_S : M_STR_D;
			st_res.token_kind = ctt_pkg::KIND_STRING;
		end else if (cls.is_mark) begin
			st_emit           = 1'b1;
			st_tok            = 1'b1;
			st_res.token_kind = cls.mark_kind;
			st_res.token_end  = 1'b1;
		end else begin
			st_emit           = 1'b1;
			st_tok            = 1'b1;
			st_mode           = M_IDENT;
			st_res.token_kind = ctt_pkg::KIND_IDENT;
			st_res.has_char   = 1'b1;
			st_res.char_value = c;
		end
	end

	always_comb begin
		r0         = '0;
		r1         = '0;
		n          = 2'd0;
		mode_d     = mode_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		if (head_word.end_of_input) begin
			r1.token_start  = 1'b1;
			r1.token_end    = 1'b1;
			r1.start_line   = ev_line;
			r1.start_column = ev_col;
			if (mode_q == M_IDENT) begin
				r0.token_kind   = ctt_pkg::KIND_IDENT;
				r0.token_end    = 1'b1;
				r0.start_line   = tk_line;
				r0.start_column = tk_col;
				n               = 2'd2;
			end else if (mode_q == M_STR_S || mode_q == M_ESC_S ||
			             mode_q == M_STR_D || mode_q == M_ESC_D) begin
				r0.error_code   = ctt_pkg::ERR_UNTERM;
				r0.start_line   = ev_line;
				r0.start_column = ev_col;
				n               = 2'd2;
			end else begin
				r0 = r1;
				n  = 2'd1;
			end
			mode_d     = M_BETWEEN;
			tok_line_d = '0;
			tok_col_d  = '0;
		end else if (mode_q == M_ERROR) begin
			n = 2'd0;
		end else if (cls.bad) begin
			r0.error_code   = ctt_pkg::ERR_BAD_BYTE;
			r0.start_line   = ev_line;
			r0.start_column = ev_col;
			n               = 2'd1;
			mode_d          = M_ERROR;
		end else begin
			r0.start_line   = tk_line;
			r0.start_column = tk_col;
			case (mode_q)
				M_COMMENT: begin
					if (cls.newline) begin
						mode_d = M_BETWEEN;
					end
				end
				M_IDENT: begin
					r0.token_kind = ctt_pkg::KIND_IDENT;
					if (!cls.space && !cls.is_mark) begin
						r0.has_char   = 1'b1;
						r0.char_value = c;
						n             = 2'd1;
					end else begin
						// close the identifier, then treat the byte as fresh
						r0.token_end = 1'b1;
						r1           = st_res;
						n            = st_emit ? 2'd2 : 2'd1;
						mode_d       = st_mode;
					end
				end
				M_STR_S, M_STR_D: begin
					if ((mode_q == M_STR_S) ? cls.squote : cls.dquote) begin
						r0.token_kind = ctt_pkg::KIND_STRING;
						r0.token_end  = 1'b1;
						n             = 2'd1;
						mode_d        = M_BETWEEN;
					end else if (cls.newline) begin
						r0.error_code   = ctt_pkg::ERR_UNTERM;
						r0.start_line   = ev_line;
						r0.start_column = ev_col;
						n               = 2'd1;
						mode_d          = M_ERROR;
					end else if (cls.bslash) begin
						mode_d = (mode_q == M_STR_S) ? M_ESC_S : M_ESC_D;
					end else begin
						r0.token_kind = ctt_pkg::KIND_STRING;
						r0.has_char   = 1'b1;
						r0.char_value = c;
						n             = 2'd1;
					end
				end
				M_ESC_S, M_ESC_D: begin
					n = 2'd1;
					if (cls.esc_known || (cls.esc_dollar && mode_q == M_ESC_D)) begin
						r0.token_kind = ctt_pkg::KIND_STRING;
						r0.has_char   = 1'b1;
						r0.char_value = cls.esc_known ? cls.esc_value : c;
						mode_d        = (mode_q == M_ESC_S) ? M_STR_S : M_STR_D;
					end else begin
						r0.error_code   = ctt_pkg::ERR_BAD_ESCAPE;
						r0.start_line   = ev_line;
						r0.start_column = ev_col;
						mode_d          = M_ERROR;
					end
				end
				default: begin
					r0     = st_res;
					n      = st_emit ? 2'd1 : 2'd0;
					mode_d = st_mode;
				end
			endcase
			if (st_tok && (mode_q == M_BETWEEN ||
			               (mode_q == M_IDENT && (cls.space || cls.is_mark)))) begin
				tok_line_d = head_word.line;
				tok_col_d  = head_word.column;
			end
		end
		r0.last_of_item = (n == 2'd1);
		r1.last_of_item = 1'b1;
	end

	// Take a word only when the output slot frees up and no second result waits.
	assign pop       = head_valid && !pend_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_BETWEEN;
			tok_line_q <= '0;
			tok_col_q  <= '0;
		end else if (pop) begin
			mode_q     <= mode_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (pend_q && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
			pend_q      <= 1'b0;
		end else if (pop) begin
			out_valid_q <= (n != 2'd0);
			pend_q      <= (n == 2'd2);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && (!out_valid_q || out_ready)) begin
			out_q <= pend_item_q;
		end else if (pop) begin
			out_q       <= r0;
			pend_item_q <= r1;
		end
	end

	a_pend_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("second result waiting with empty output slot");

	a_pend_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !out_q.last_of_item)
		else $error("first of a result pair flagged as last");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && mode_q == M_ERROR && !head_word.end_of_input) |=> !out_valid_q)
		else $error("byte after an error produced a result");

	a_error_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.error_code != ctt_pkg::ERR_NONE) |->
		(out_q.token_kind == ctt_pkg::KIND_EOF && !out_q.token_start &&
		 !out_q.token_end && !out_q.has_char))
		else $error("error result carries token fields");

endmodule

// File: tb/sv/config_text_tokenizer_unit_tb.sv
// Self-checking testbench of config_text_tokenizer_unit: random and directed text words,
// predicted token events compared in order. Depends on ctt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module config_text_tokenizer_unit_tb;

	typedef logic [ctt_pkg::PosBits-1:0] pos_t;

	typedef enum logic [2:0] {
		LX_BETWEEN, LX_COMMENT, LX_STR_S, LX_ESC_S, LX_STR_D, LX_ESC_D, LX_IDENT, LX_ERROR
	} lex_mode_t;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BLANK  = " ";
	localparam logic [7:0] CH_HASH   = "#";
	localparam logic [7:0] CH_DOLLAR = "$";
	localparam logic [7:0] CH_SQUOTE = "'";
	localparam logic [7:0] CH_DQUOTE = "\"";
	localparam logic [7:0] CH_BSLASH = "\\";
	localparam logic [7:0] CH_ZERO   = "0";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_EQUAL  = "=";
	localparam logic [7:0] CH_COLON  = ":";
	localparam logic [7:0] CH_SEMI   = ";";

	localparam int FLAW_NONE    = 0;
	localparam int FLAW_NEWLINE = 1;
	localparam int FLAW_ESCAPE  = 2;
	localparam int FLAW_END     = 3;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	ctt_pkg::in_item_t  in_item   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ctt_pkg::out_item_t out_item;

	ctt_pkg::in_item_t  text_words[$];
	ctt_pkg::out_item_t events_due[$];
	ctt_pkg::out_item_t word_events[2];
	int                 n_events;
	int                 words_made = 0;
	int                 bad_events = 0;
	int                 send_idle  = 0;
	int                 recv_idle  = 0;

	lex_mode_t lx_mode;
	pos_t      cur_line, cur_col, tok_line, tok_col;

	config_text_tokenizer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------- token event predictor ----------------

	function automatic pos_t step_position(input pos_t v);
		return (v == ctt_pkg::PosMax) ? v : v + 1'b1;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_BLANK || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_CR;
	endfunction

	// KIND_EOF stands for "not a mark"
	function automatic ctt_pkg::kind_t mark_of(input logic [7:0] c);
		case (c)
			CH_LBRACE: return ctt_pkg::KIND_LBRACE;
			CH_RBRACE: return ctt_pkg::KIND_RBRACE;
			CH_EQUAL:  return ctt_pkg::KIND_EQUAL;
			CH_COLON:  return ctt_pkg::KIND_COLON;
			CH_SEMI:   return ctt_pkg::KIND_SEMI;
			default:   return ctt_pkg::KIND_EOF;
		endcase
	endfunction

	// Bit 8 flags a known escape, bits 7:0 hold the decoded byte.
	function automatic logic [8:0] escape_of(input logic [7:0] c, input logic dq);
		case (c)
			CH_BSLASH, CH_SQUOTE, CH_DQUOTE: return {1'b1, c};
			CH_ZERO:   return {1'b1, 8'h00};
			"t":       return {1'b1, CH_TAB};
			"v":       return {1'b1, CH_VT};
			"r":       return {1'b1, CH_CR};
			"n":       return {1'b1, CH_NL};
			CH_DOLLAR: return {dq, CH_DOLLAR};
			default:   return 9'h000;
		endcase
	endfunction

	function automatic void lex_reset();
		lx_mode  = LX_BETWEEN;
		cur_line = pos_t'(1);
		cur_col  = '0;
		tok_line = '0;
		tok_col  = '0;
	endfunction

	function automatic void add_event(input ctt_pkg::kind_t k, input logic st,
			input logic en, input logic hc, input logic [7:0] ch, input pos_t ln,
			input pos_t cl, input ctt_pkg::err_t e);
		ctt_pkg::out_item_t ev;
		ev.token_kind   = k;
		ev.token_start  = st;
		ev.token_end    = en;
		ev.has_char     = hc;
		ev.char_value   = hc ? ch : 8'h00;
		ev.start_line   = ctt_pkg::FieldPos'(ln);
		ev.start_column = ctt_pkg::FieldPos'(cl);
		ev.error_code   = e;
		ev.last_of_item = 1'b0;
		if (n_events < 2) begin
			word_events[n_events] = ev;
			n_events++;
		end
	endfunction

	function automatic void open_token(input logic [7:0] c);
		if (c == CH_HASH) begin
			lx_mode = LX_COMMENT;
		end else if (!is_blank(c)) begin
			tok_line = cur_line;
			tok_col  = cur_col;
			if (c == CH_SQUOTE || c == CH_DQUOTE) begin
				lx_mode = (c == CH_SQUOTE) ? LX_STR_S : LX_STR_D;
				add_event(ctt_pkg::KIND_STRING, 1'b1, 1'b0, 1'b0, 8'h00, tok_line, tok_col,
					ctt_pkg::ERR_NONE);
			end else if (mark_of(c) != ctt_pkg::KIND_EOF) begin
				add_event(mark_of(c), 1'b1, 1'b1, 1'b0, 8'h00, tok_line, tok_col,
					ctt_pkg::ERR_NONE);
			end else begin
				lx_mode = LX_IDENT;
				add_event(ctt_pkg::KIND_IDENT, 1'b1, 1'b0, 1'b1, c, tok_line, tok_col,
					ctt_pkg::ERR_NONE);
			end
		end
	endfunction

	// Advance the predictor by one accepted word and queue the events it owes.
	function automatic void lex_word(input ctt_pkg::in_item_t w);
		pos_t       eof_col;
		logic [8:0] esc;
		logic [7:0] c;
		n_events = 0;
		c = w.text_byte;
		if (w.end_of_input) begin
			eof_col = step_position(cur_col);
			if (lx_mode == LX_IDENT)
				add_event(ctt_pkg::KIND_IDENT, 1'b0, 1'b1, 1'b0, 8'h00, tok_line, tok_col,
					ctt_pkg::ERR_NONE);
			else if (lx_mode == LX_STR_S || lx_mode == LX_ESC_S ||
					lx_mode == LX_STR_D || lx_mode == LX_ESC_D)
				add_event(ctt_pkg::KIND_EOF, 1'b0, 1'b0, 1'b0, 8'h00, cur_line, eof_col,
					ctt_pkg::ERR_UNTERM);
			add_event(ctt_pkg::KIND_EOF, 1'b1, 1'b1, 1'b0, 8'h00, cur_line, eof_col,
				ctt_pkg::ERR_NONE);
			lex_reset();
		end else begin
			if (c == CH_NL) begin
				cur_line = step_position(cur_line);
				cur_col  = '0;
			end else begin
				cur_col = step_position(cur_col);
			end
			if (lx_mode != LX_ERROR) begin
				if (c == 8'h00 || c[7]) begin
					add_event(ctt_pkg::KIND_EOF, 1'b0, 1'b0, 1'b0, 8'h00, cur_line, cur_col,
						ctt_pkg::ERR_BAD_BYTE);
					lx_mode = LX_ERROR;
				end else begin
					case (lx_mode)
						LX_COMMENT: begin
							if (c == CH_NL)
								lx_mode = LX_BETWEEN;
						end
						LX_IDENT: begin
							if (!is_blank(c) && mark_of(c) == ctt_pkg::KIND_EOF) begin
								add_event(ctt_pkg::KIND_IDENT, 1'b0, 1'b0, 1'b1, c,
									tok_line, tok_col, ctt_pkg::ERR_NONE);
							end else begin
								// close the identifier, then treat the byte afresh
								add_event(ctt_pkg::KIND_IDENT, 1'b0, 1'b1, 1'b0, 8'h00,
									tok_line, tok_col, ctt_pkg::ERR_NONE);
								lx_mode = LX_BETWEEN;
								open_token(c);
							end
						end
						LX_STR_S, LX_STR_D: begin
							if (c == ((lx_mode == LX_STR_S) ? CH_SQUOTE : CH_DQUOTE)) begin
								add_event(ctt_pkg::KIND_STRING, 1'b0, 1'b1, 1'b0, 8'h00,
									tok_line, tok_col, ctt_pkg::ERR_NONE);
								lx_mode = LX_BETWEEN;
							end else if (c == CH_NL) begin
								add_event(ctt_pkg::KIND_EOF, 1'b0, 1'b0, 1'b0, 8'h00,
									cur_line, cur_col, ctt_pkg::ERR_UNTERM);
								lx_mode = LX_ERROR;
							end else if (c == CH_BSLASH) begin
								lx_mode = (lx_mode == LX_STR_S) ? LX_ESC_S : LX_ESC_D;
							end else begin
								add_event(ctt_pkg::KIND_STRING, 1'b0, 1'b0, 1'b1, c,
									tok_line, tok_col, ctt_pkg::ERR_NONE);
							end
						end
						LX_ESC_S, LX_ESC_D: begin
							esc = escape_of(c, lx_mode == LX_ESC_D);
							if (!esc[8]) begin
								add_event(ctt_pkg::KIND_EOF, 1'b0, 1'b0, 1'b0, 8'h00,
									cur_line, cur_col, ctt_pkg::ERR_BAD_ESCAPE);
								lx_mode = LX_ERROR;
							end else begin
								add_event(ctt_pkg::KIND_STRING, 1'b0, 1'b0, 1'b1, esc[7:0],
									tok_line, tok_col, ctt_pkg::ERR_NONE);
								lx_mode = (lx_mode == LX_ESC_S) ? LX_STR_S : LX_STR_D;
							end
						end
						default: begin
							lx_mode = LX_BETWEEN;
							open_token(c);
						end
					endcase
				end
			end
		end
		if (n_events > 0)
			word_events[n_events-1].last_of_item = 1'b1;
		for (int i = 0; i < n_events; i++)
			events_due.push_back(word_events[i]);
	endfunction

	// ---------------- text generation ----------------

	function automatic void push_word(input logic [7:0] b, input logic eoi, input logic counted);
		ctt_pkg::in_item_t w;
		w.text_byte    = b;
		w.end_of_input = eoi;
		text_words.push_back(w);
		if (counted)
			words_made++;
	endfunction

	function automatic void push_end();
		push_word(8'($urandom_range(255)), 1'b1, 1'b1);
	endfunction

	// Bytes after an error are swallowed until the end mark.
	function automatic void push_absorbed_then_end();
		repeat ($urandom_range(3))
			push_word(8'($urandom_range(255)), 1'b0, 1'b0);
		push_end();
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(4))
			0:       return CH_TAB;
			1:       return CH_NL;
			2:       return CH_VT;
			3:       return CH_CR;
			default: return CH_BLANK;
		endcase
	endfunction

	function automatic logic [7:0] ident_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 127));
		while (mark_of(c) != ctt_pkg::KIND_EOF);
		return c;
	endfunction

	function automatic logic [7:0] string_char(input logic [7:0] q);
		logic [7:0] c;
		if ($urandom_range(15) == 0)
			return CH_TAB;
		do
			c = 8'($urandom_range(32, 127));
		while (c == q || c == CH_BSLASH);
		return c;
	endfunction

	function automatic logic [7:0] known_escape(input logic dq);
		case ($urandom_range(dq ? 8 : 7))
			0:       return CH_BSLASH;
			1:       return CH_ZERO;
			2:       return CH_SQUOTE;
			3:       return CH_DQUOTE;
			4:       return "t";
			5:       return "v";
			6:       return "r";
			7:       return "n";
			default: return CH_DOLLAR;
		endcase
	endfunction

	function automatic logic [7:0] unknown_escape(input logic dq);
		logic [7:0] c;
		logic [8:0] esc;
		do begin
			c   = ($urandom_range(3) == 0 && !dq) ? CH_DOLLAR : 8'($urandom_range(33, 126));
			esc = escape_of(c, dq);
		end while (esc[8]);
		return c;
	endfunction

	function automatic logic [7:0] mark_char();
		case ($urandom_range(4))
			0:       return CH_LBRACE;
			1:       return CH_RBRACE;
			2:       return CH_EQUAL;
			3:       return CH_COLON;
			default: return CH_SEMI;
		endcase
	endfunction

	function automatic logic [7:0] bad_char();
		return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(8'h80, 8'hFF));
	endfunction

	function automatic void add_string(input logic dq, input int flaw);
		logic [7:0] q;
		int         len;
		q   = dq ? CH_DQUOTE : CH_SQUOTE;
		len = $urandom_range(6);
		push_word(q, 1'b0, 1'b1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(3) == 0) begin
				push_word(CH_BSLASH, 1'b0, 1'b1);
				push_word(known_escape(dq), 1'b0, 1'b1);
			end else begin
				push_word(string_char(q), 1'b0, 1'b1);
			end
		end
		case (flaw)
			FLAW_NONE:    push_word(q, 1'b0, 1'b1);
			FLAW_NEWLINE: push_word(CH_NL, 1'b0, 1'b1);
			FLAW_ESCAPE: begin
				push_word(CH_BSLASH, 1'b0, 1'b1);
				push_word(unknown_escape(dq), 1'b0, 1'b1);
			end
			default:      push_end();
		endcase
		if (flaw == FLAW_NEWLINE || flaw == FLAW_ESCAPE)
			push_absorbed_then_end();
	endfunction

	function automatic void add_fragment();
		int         r;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 14) begin
			repeat ($urandom_range(1, 3))
				push_word(blank_char(), 1'b0, 1'b1);
		end else if (r < 22) begin
			push_word(CH_HASH, 1'b0, 1'b1);
			repeat ($urandom_range(6)) begin
				do
					b = 8'($urandom_range(1, 127));
				while (b == CH_NL);
				push_word(b, 1'b0, 1'b1);
			end
			push_word(CH_NL, 1'b0, 1'b1);
		end else if (r < 44) begin
			repeat ($urandom_range(1, 6))
				push_word(ident_char(), 1'b0, 1'b1);
			case ($urandom_range(4))
				0, 1:    push_word(blank_char(), 1'b0, 1'b1);
				2, 3:    push_word(mark_char(), 1'b0, 1'b1);
				default: ;
			endcase
		end else if (r < 56) begin
			push_word(mark_char(), 1'b0, 1'b1);
		end else if (r < 84) begin
			add_string(r >= 70, FLAW_NONE);
		end else if (r < 89) begin
			push_end();
		end else if (r < 92) begin
			add_string($urandom_range(1), $urandom_range(FLAW_NEWLINE, FLAW_END));
		end else if (r < 95) begin
			// bad byte inside an open token or comment, or between tokens
			case ($urandom_range(3))
				0:       push_word(CH_HASH, 1'b0, 1'b1);
				1:       push_word(ident_char(), 1'b0, 1'b1);
				2:       push_word($urandom_range(1) ? CH_DQUOTE : CH_SQUOTE, 1'b0, 1'b1);
				default: ;
			endcase
			push_word(bad_char(), 1'b0, 1'b1);
			push_absorbed_then_end();
		end else begin
			b = 8'($urandom_range(255));
			push_word(b, 1'b0, 1'b1);
			if (b == 8'h00 || b[7])
				push_absorbed_then_end();
		end
	endfunction

	function automatic void load_directed();
		// identifier swallowing '#', then every mark
		push_word("a", 1'b0, 1'b1);
		push_word(CH_HASH, 1'b0, 1'b1);
		push_word(CH_LBRACE, 1'b0, 1'b1);
		push_word(CH_RBRACE, 1'b0, 1'b1);
		push_word(CH_EQUAL, 1'b0, 1'b1);
		push_word(CH_COLON, 1'b0, 1'b1);
		push_word(CH_SEMI, 1'b0, 1'b1);
		// double string: dollar escape, vertical tab escape, highest good byte
		push_word(CH_DQUOTE, 1'b0, 1'b1);
		push_word(CH_BSLASH, 1'b0, 1'b1);
		push_word(CH_DOLLAR, 1'b0, 1'b1);
		push_word(CH_BSLASH, 1'b0, 1'b1);
		push_word("v", 1'b0, 1'b1);
		push_word(8'h7F, 1'b0, 1'b1);
		push_word(CH_DQUOTE, 1'b0, 1'b1);
		// dollar is not an escape in single quotes
		push_word(CH_SQUOTE, 1'b0, 1'b1);
		push_word(CH_BSLASH, 1'b0, 1'b1);
		push_word(CH_DOLLAR, 1'b0, 1'b1);
		push_word(8'hFF, 1'b0, 1'b0);
		push_word(8'hFF, 1'b1, 1'b1);
		// newline inside a string
		push_word(CH_SQUOTE, 1'b0, 1'b1);
		push_word(CH_NL, 1'b0, 1'b1);
		push_word(8'h00, 1'b1, 1'b1);
		// end mark inside a string
		push_word(CH_DQUOTE, 1'b0, 1'b1);
		push_word(8'h00, 1'b1, 1'b1);
		// NUL byte
		push_word(8'h00, 1'b0, 1'b1);
		push_word(8'hFF, 1'b1, 1'b1);
	endfunction

	function automatic void load_random(input int count);
		int target;
		target = words_made + count;
		while (words_made < target)
			add_fragment();
		push_end();
	endfunction

	// ---------------- driver and monitor ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				lex_word(in_item);
			if (!in_valid || in_ready) begin
				if (text_words.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_item  <= text_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic string event_text(input ctt_pkg::out_item_t e);
		return $sformatf("kind %0d start %b end %b char %b/%02h at %0d:%0d err %0d last %b",
			e.token_kind, e.token_start, e.token_end, e.has_char, e.char_value,
			e.start_line, e.start_column, e.error_code, e.last_of_item);
	endfunction

	always @(posedge clk) begin
		ctt_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (events_due.size() == 0) begin
					if (bad_events < 10)
						$display("%0t: unexpected event: %s", $realtime, event_text(out_item));
					bad_events++;
				end else begin
					want = events_due.pop_front();
					if (out_item.token_kind !== want.token_kind ||
							out_item.token_start !== want.token_start ||
							out_item.token_end !== want.token_end ||
							out_item.has_char !== want.has_char ||
							out_item.char_value !== want.char_value ||
							out_item.start_line !== want.start_line ||
							out_item.start_column !== want.start_column ||
							out_item.error_code !== want.error_code ||
							out_item.last_of_item !== want.last_of_item) begin
						if (bad_events < 10) begin
							$display("%0t: event mismatch", $realtime);
							$display("  expected %s", event_text(want));
							$display("  actual   %s", event_text(out_item));
						end
						bad_events++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// ---------------- sequencing ----------------

	task automatic drain();
		while (text_words.size() != 0 || in_valid || events_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		lex_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_idle = 6;
		recv_idle = 66;
		load_directed();
		load_random(525);
		drain();

		send_idle = 66;
		recv_idle = 6;
		load_random(525);
		drain();

		send_idle = 0;
		recv_idle = 0;
		load_random(525);
		drain();

		// let any stray event show up
		repeat (10) @(posedge clk);
		if (bad_events == 0)
			$display("config_text_tokenizer_unit test passed");
		else
			$display("config_text_tokenizer_unit test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("config_text_tokenizer_unit test failed");
		$finish;
	end

endmodule
